@@ rtl/bss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bss_pkg;

	// Field widths of one input item and one result item.
	localparam int ADDR_W  = 16;
	localparam int PIX_W   = 16;
	localparam int COORD_W = 16;
	localparam int OUT_W   = 24;
	localparam int CFG_W   = 9;

	// Bit positions inside the input tdata word.
	localparam int IN_ADDR_LSB  = 0;
	localparam int IN_VALUE_LSB = 16;
	localparam int IN_X_LSB     = 32;
	localparam int IN_Y_LSB     = 48;
	localparam int IN_TDATA_W   = 64;

	// Item kinds carried in tuser.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Register indexes (byte address bit 2).
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 9'd256;

	localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
	localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [1:0] tap;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_sample;
		logic oor;
	} dp_status_t;

endpackage
`default_nettype wire

@@ rtl/bss_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bss_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [2:0]                   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [bss_pkg::CFG_W-1:0]    image_width,
	output logic [bss_pkg::CFG_W-1:0]    image_height
);

	logic [bss_pkg::CFG_W-1:0] image_width_q;
	logic [bss_pkg::CFG_W-1:0] image_height_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bss_pkg::IMAGE_WIDTH_RST;
			image_height_q <= bss_pkg::IMAGE_HEIGHT_RST;
		end else if (wr_en) begin
			if (paddr[2] == bss_pkg::REG_IMAGE_WIDTH) begin
				image_width_q <= pwdata[bss_pkg::CFG_W-1:0];
			end else begin
				image_height_q <= pwdata[bss_pkg::CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == bss_pkg::REG_IMAGE_WIDTH) begin
			prdata = 32'(image_width_q);
		end else begin
			prdata = 32'(image_height_q);
		end
	end

	assign image_width  = image_width_q;
	assign image_height = image_height_q;

endmodule
`default_nettype wire

@@ rtl/bss_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bss_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	input  bss_pkg::dp_status_t  sts,
	output bss_pkg::ctrl_cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_MAC  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [1:0] tap_q;
	logic       m_valid_q;
	logic       accept;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d      = state_q;
		cmd.load     = accept;
		cmd.rd_en    = 1'b0;
		cmd.tap      = tap_q;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.is_sample) begin
					state_d = sts.oor ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				if (tap_q == 2'd3) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				// The last tap is accumulated in this cycle.
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tap_q     <= 2'd0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) begin
				tap_q <= tap_q + 2'd1;
			end else begin
				tap_q <= 2'd0;
			end
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;

endmodule
`default_nettype wire

@@ rtl/bss_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bss_dp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [bss_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire  [0:0]                        s_tuser,
	input  wire  [bss_pkg::CFG_W-1:0]         image_width,
	input  wire  [bss_pkg::CFG_W-1:0]         image_height,
	input  bss_pkg::ctrl_cmd_t                cmd,
	output bss_pkg::dp_status_t               sts,
	output logic [bss_pkg::OUT_W-1:0]         m_tdata,
	output logic [0:0]                        m_tuser
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int IW    = bss_pkg::COORD_W - FRAC_BITS;
	localparam int MW    = IW + DW;
	localparam int WGW   = 2 * FRAC_BITS + 1;
	localparam int PW    = bss_pkg::PIX_W + WGW + 1;
	localparam int ACCW  = PW + 2;
	localparam int RW    = ACCW - FRAC_BITS;

	localparam logic [FRAC_BITS:0]       ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [ACCW-1:0]   RND    = ACCW'(64'd1 << (FRAC_BITS - 1));

	logic [bss_pkg::ADDR_W-1:0]         pix_addr;
	logic signed [bss_pkg::PIX_W-1:0]   pix_value;
	logic [bss_pkg::COORD_W-1:0]        sx;
	logic [bss_pkg::COORD_W-1:0]        sy;
	logic [IW-1:0]                      x0_in;
	logic [IW-1:0]                      y0_in;
	logic [DW-1:0]                      w_eff;
	logic [HW-1:0]                      h_eff;
	logic [MW-1:0]                      base_full;
	logic                               is_sample;

	logic [AW-1:0]                      base_q;
	logic [DW-1:0]                      wdt_q;
	logic [FRAC_BITS-1:0]               fx_q;
	logic [FRAC_BITS-1:0]               fy_q;
	logic                               oor_q;

	logic signed [bss_pkg::PIX_W-1:0]   mem [DEPTH];
	logic [AW-1:0]                      rd_addr;
	logic [FRAC_BITS:0]                 wx;
	logic [FRAC_BITS:0]                 wy;
	logic [2*FRAC_BITS+1:0]             wgt_full;

	logic signed [bss_pkg::PIX_W-1:0]   rd_data_s1;
	logic [WGW-1:0]                     wgt_s1;
	logic                               mac_v_s1;

	logic signed [PW-1:0]               prod;
	logic signed [ACCW-1:0]             acc_q;
	logic signed [ACCW-1:0]             rsum;
	logic signed [RW-1:0]               res;
	logic signed [bss_pkg::OUT_W-1:0]   sat_val;

	logic [bss_pkg::OUT_W-1:0]          out_value_q;
	logic                               out_oor_q;

	assign pix_addr  = s_tdata[bss_pkg::IN_ADDR_LSB +: bss_pkg::ADDR_W];
	assign pix_value = s_tdata[bss_pkg::IN_VALUE_LSB +: bss_pkg::PIX_W];
	assign sx        = s_tdata[bss_pkg::IN_X_LSB +: bss_pkg::COORD_W];
	assign sy        = s_tdata[bss_pkg::IN_Y_LSB +: bss_pkg::COORD_W];
	assign x0_in     = sx[bss_pkg::COORD_W-1 -: IW];
	assign y0_in     = sy[bss_pkg::COORD_W-1 -: IW];
	assign is_sample = (s_tuser[0] == bss_pkg::CMD_SAMPLE);

	// Dimensions above the store size are used as the store size.
	always_comb begin
		if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = DW'(image_width);
		end
		if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height);
		end
	end

	assign sts.is_sample = is_sample;
	assign sts.oor       = (32'(x0_in) + 32'd1 >= 32'(w_eff)) ||
	                       (32'(y0_in) + 32'd1 >= 32'(h_eff));

	assign base_full = MW'(y0_in) * MW'(w_eff) + MW'(x0_in);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= AW'(base_full);
			wdt_q  <= w_eff;
			fx_q   <= sx[FRAC_BITS-1:0];
			fy_q   <= sy[FRAC_BITS-1:0];
			oor_q  <= sts.oor;
		end
	end

	// Taps in order: top left, top right, bottom left, bottom right.
	assign rd_addr = base_q + (cmd.tap[0] ? AW'(1) : AW'(0))
	                        + (cmd.tap[1] ? AW'(wdt_q) : AW'(0));

	assign wx       = cmd.tap[0] ? {1'b0, fx_q} : ONE_FX - {1'b0, fx_q};
	assign wy       = cmd.tap[1] ? {1'b0, fy_q} : ONE_FX - {1'b0, fy_q};
	assign wgt_full = wx * wy;

	always_ff @(posedge clk) begin
		if (cmd.load && !is_sample && (32'(pix_addr) < 32'(DEPTH))) begin
			mem[AW'(pix_addr)] <= pix_value;
		end else if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			wgt_s1 <= WGW'(wgt_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.rd_en;
		end
	end

	assign prod = rd_data_s1 * $signed({1'b0, wgt_s1});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (mac_v_s1) begin
			acc_q <= acc_q + ACCW'(prod);
		end
	end

	// Round half up, then floor by the fraction width.
	assign rsum = acc_q + RND;
	assign res  = rsum[ACCW-1:FRAC_BITS];

	always_comb begin
		if (32'(res) > bss_pkg::OUT_MAX) begin
			sat_val = bss_pkg::OUT_W'(bss_pkg::OUT_MAX);
		end else if (32'(res) < bss_pkg::OUT_MIN) begin
			sat_val = bss_pkg::OUT_W'(bss_pkg::OUT_MIN);
		end else begin
			sat_val = bss_pkg::OUT_W'(res);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= oor_q ? '0 : sat_val;
			out_oor_q   <= oor_q;
		end
	end

	assign m_tdata    = out_value_q;
	assign m_tuser[0] = out_oor_q;

endmodule
`default_nettype wire

@@ rtl/bilinear_subpixel_sampler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Bilinear sampler over a stored image of signed 16-bit pixels.
// The slave stream carries two kinds of transaction, chosen by tuser: a pixel
// write, stored at a row-major address in a single-port image memory, and a
// sample request at unsigned fixed-point coordinates. Each sample yields one
// transaction on the master stream: the rounded interpolated value and a flag
// that is set, with a value of zero, when a right or lower neighbour lies
// outside the configured image. Writes yield nothing.
// A write leaves the sampler ready for another item. An in-range sample
// holds off new input until its result is loaded: the four neighbours are
// read one a cycle from the single memory port, then multiplied and
// accumulated one a cycle, and the result is rounded into the output
// register once that register is free. An out-of-range sample skips the
// reads and loads its flagged result. The image width and height are set
// over the APB port; the user must do so while idle, unchecked by the block.
// Reset clears the controller and both dimension registers to 256; the image
// memory is not cleared and must be written before it is sampled. A result
// waits in the output register while the receiver stalls; a further sample
// is taken, but its result waits until the register has been emptied.
module bilinear_subpixel_sampler_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// pixel_addr[15:0], pixel_value[31:16], sample_x[47:32], sample_y[63:48]
	input  wire  [63:0] s_tdata,
	// command[0]
	input  wire  [0:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// interp_value[23:0]
	output logic [23:0] m_tdata,
	// out_of_range[0]
	output logic [0:0]  m_tuser,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [bss_pkg::CFG_W-1:0] image_width;
	logic [bss_pkg::CFG_W-1:0] image_height;
	bss_pkg::ctrl_cmd_t        cmd;
	bss_pkg::dp_status_t       sts;

	bss_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.image_width  (image_width),
		.image_height (image_height)
	);

	bss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bss_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.image_width  (image_width),
		.image_height (image_height),
		.cmd          (cmd),
		.sts          (sts),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule
`default_nettype wire

@@ rtl/bss_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bss_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [0:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire [0:0]  m_tuser
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// A pixel write never produces a result transaction.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser[0] == bss_pkg::CMD_WRITE) && !m_tvalid |=> !m_tvalid)
		else $error("result appeared after a pixel write");

	// The sampler works on one sample at a time.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser[0] == bss_pkg::CMD_SAMPLE) |=> !s_tready)
		else $error("input accepted while a sample is in progress");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a sample in progress");

endmodule

bind bilinear_subpixel_sampler_top bss_checker u_bss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
